@@ src/gpioc_pkg.sv @@
package gpioc_pkg;

    // Bank geometry
    localparam int NUM_PORTS = 9;
    localparam int PORT_W    = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    typedef logic [PORT_W-1:0] port_t;

    // Port B carries the weak pull-ups and the change compare
    localparam port_t PORT_B = port_t'(1);

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [0:0] {
        REG_PULLUPS_OFF = 1'b0
    } cfg_reg_e;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_SAMPLE = 2'd2
    } op_e;

    typedef enum logic [1:0] {
        KIND_DIR   = 2'd0,
        KIND_LATCH = 2'd1,
        KIND_PINS  = 2'd2,
        KIND_FLAG  = 2'd3
    } kind_e;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] port_index;
        logic [1:0] reg_kind;
        logic [7:0] write_data;
        logic [7:0] pin_levels;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] drive_enable;
        logic [7:0] drive_level;
        logic [7:0] pullup_on;
        logic       change_flag;
    } result_t;

endpackage

@@ src/gpioc_cfg.sv @@
module gpioc_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gpioc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [gpioc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [gpioc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready,
    output logic                             pullups_off
);
    import gpioc_pkg::*;

    logic     pullups_off_reg;
    logic     pullups_off_next;
    cfg_reg_e reg_sel;
    logic     wr_en;

    // Word address: drop the byte offset
    assign reg_sel = cfg_reg_e'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        pullups_off_next = pullups_off_reg;
        if (wr_en && (reg_sel == REG_PULLUPS_OFF))
        begin
            pullups_off_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pullups_off_reg <= 1'b1;
        end
        else
        begin
            pullups_off_reg <= pullups_off_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel == REG_PULLUPS_OFF)
        begin
            prdata[0] = pullups_off_reg;
        end
    end

    assign pready      = 1'b1;
    assign pullups_off = pullups_off_reg;

endmodule

@@ src/gpioc_bank.sv @@
module gpioc_bank (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                process,
    input  gpioc_pkg::item_t    item,
    input  logic                pullups_off,
    output gpioc_pkg::result_t  result
);
    import gpioc_pkg::*;

    logic [7:0] dir_reg   [NUM_PORTS];
    logic [7:0] latch_reg [NUM_PORTS];
    logic [7:0] samp_reg  [NUM_PORTS];
    logic [3:0] last_read_reg;
    logic [3:0] last_read_next;
    logic       flag_reg;
    logic       flag_next;

    port_t      p;
    logic       is_b;
    logic       dir_we;
    logic       latch_we;
    logic       samp_we;
    logic       flag_we;
    logic       pins_read;
    logic [7:0] rd;
    logic [7:0] pin_p;
    logic [7:0] dir_p_new;
    logic [7:0] latch_p_new;
    logic [7:0] dir_b_new;
    logic [7:0] latch_b_new;
    logic [7:0] samp_b_new;
    logic [7:0] pin_b_new;
    logic       flag_mid;
    logic       mismatch;

    // Out-of-range port falls back to port A
    assign p    = (int'(item.port_index) < NUM_PORTS) ? item.port_index[PORT_W-1:0] : '0;
    assign is_b = (p == PORT_B);

    assign pin_p = (latch_reg[p] & ~dir_reg[p]) | (samp_reg[p] & dir_reg[p]);

    always_comb
    begin
        dir_we    = 1'b0;
        latch_we  = 1'b0;
        samp_we   = 1'b0;
        flag_we   = 1'b0;
        pins_read = 1'b0;
        rd        = '0;
        unique case (item.op)
            OP_READ:
            begin
                unique case (item.reg_kind)
                    KIND_DIR:   rd = dir_reg[p];
                    KIND_LATCH: rd = latch_reg[p];
                    KIND_PINS:
                    begin
                        rd        = pin_p;
                        pins_read = 1'b1;
                    end
                    KIND_FLAG:  rd = {7'd0, flag_reg};
                endcase
            end
            OP_WRITE:
            begin
                unique case (item.reg_kind)
                    KIND_DIR:   dir_we   = 1'b1;
                    KIND_LATCH: latch_we = 1'b1;
                    KIND_PINS:  latch_we = 1'b1;
                    KIND_FLAG:  flag_we  = 1'b1;
                endcase
            end
            OP_SAMPLE: samp_we = 1'b1;
            default: ;
        endcase
    end

    // State as it stands after this transaction
    assign dir_p_new   = dir_we   ? item.write_data : dir_reg[p];
    assign latch_p_new = latch_we ? item.write_data : latch_reg[p];
    assign dir_b_new   = (dir_we   && is_b) ? item.write_data : dir_reg[PORT_B];
    assign latch_b_new = (latch_we && is_b) ? item.write_data : latch_reg[PORT_B];
    assign samp_b_new  = (samp_we  && is_b) ? item.pin_levels : samp_reg[PORT_B];

    assign last_read_next = (pins_read && is_b) ? rd[7:4] : last_read_reg;
    assign flag_mid       = flag_we ? item.write_data[0] : flag_reg;

    // Compare port B input pins 7..4 against the value seen at the last read
    assign pin_b_new = (latch_b_new & ~dir_b_new) | (samp_b_new & dir_b_new);
    assign mismatch  = |((pin_b_new[7:4] ^ last_read_next) & dir_b_new[7:4]);
    assign flag_next = flag_mid | mismatch;

    always_comb
    begin
        result.read_data    = rd;
        result.drive_enable = ~dir_p_new;
        result.drive_level  = latch_p_new & ~dir_p_new;
        result.pullup_on    = pullups_off ? 8'd0 : dir_b_new;
        result.change_flag  = flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                dir_reg[i]   <= 8'hFF;
                latch_reg[i] <= 8'h00;
                samp_reg[i]  <= 8'h00;
            end
            last_read_reg <= '0;
            flag_reg      <= 1'b0;
        end
        else if (process)
        begin
            if (dir_we)
            begin
                dir_reg[p] <= item.write_data;
            end
            if (latch_we)
            begin
                latch_reg[p] <= item.write_data;
            end
            if (samp_we)
            begin
                samp_reg[p] <= item.pin_levels;
            end
            last_read_reg <= last_read_next;
            flag_reg      <= flag_next;
        end
    end

endmodule

@@ src/gpio_ports_with_change_interrupt.sv @@
// Path: an accepted transaction waits in the input register, passes through the port
//   bank logic into the result register and is presented from there.
// Throughput: one transaction per cycle while the result side is not stalled, set by
//   the single input-register to result-register pass through the port bank logic.
// Reset (rst_n, asynchronous, active low): every pin input, latches and samples zero,
//   change flag clear, pull-ups disabled, both pipeline stages empty.
module gpio_ports_with_change_interrupt (
    input  logic                             clk,
    input  logic                             rst_n,
    // Item channel
    input  logic                             item_valid,
    output logic                             item_stall,
    input  gpioc_pkg::item_t                 item,
    // Result channel
    output logic                             result_valid,
    input  logic                             result_stall,
    output gpioc_pkg::result_t               result,
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gpioc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [gpioc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [gpioc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready
);
    import gpioc_pkg::*;

    // Input register: holds the transaction waiting to be processed
    logic    s1_valid_reg;
    logic    s1_valid_next;
    item_t   s1_item_reg;

    // Result register
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_result_reg;

    logic    advance;
    logic    process;
    logic    take;
    logic    pullups_off;
    result_t bank_result;

    // Advance whenever the result register is empty or being drained this cycle
    assign advance    = !out_valid_reg || !result_stall;
    assign process    = s1_valid_reg && advance;
    // Stall only while a transaction sits in the input register and cannot move
    assign item_stall = s1_valid_reg && !advance;
    assign take       = item_valid && !item_stall;

    gpioc_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .pullups_off (pullups_off)
    );

    // Port state and the single-pass read, write, sample and change compare
    gpioc_bank u_bank (
        .clk         (clk),
        .rst_n       (rst_n),
        .process     (process),
        .item        (s1_item_reg),
        .pullups_off (pullups_off),
        .result      (bank_result)
    );

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
            s1_valid_next  = 1'b0;
        end
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: load on acceptance and on processing, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_item_reg <= item;
        end
        if (process)
        begin
            out_result_reg <= bank_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_result_reg;

endmodule

@@ src/gpioc_checker.sv @@
module gpioc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             item_valid,
    input logic                             item_stall,
    input gpioc_pkg::item_t                 item,
    input logic                             result_valid,
    input logic                             result_stall,
    input gpioc_pkg::result_t               result,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [gpioc_pkg::CFG_ADDR_W-1:0] paddr,
    input logic [gpioc_pkg::CFG_DATA_W-1:0] pwdata,
    input logic [gpioc_pkg::CFG_DATA_W-1:0] prdata,
    input logic                             pready
);
    import gpioc_pkg::*;

    // Hold a stalled item transaction until it is taken
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_stall) |=> (item_valid && $stable(item)))
        else $error("stalled item transaction changed");

    // Hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result transaction changed");

    // Stall the item side only when the result side is full and stalled
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("item stall without a blocked result");

    // Never drive a level on a pin that is not enabled
    a_drive_masked: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.drive_level & ~result.drive_enable) == 8'd0))
        else $error("drive level outside drive enable");

    // A write to the pull-up register reads back on the next cycle
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr[CFG_ADDR_W-1:2] == REG_PULLUPS_OFF))
        |=> (prdata[0] == $past(pwdata[0])))
        else $error("pull-up register readback mismatch");

endmodule

bind gpio_ports_with_change_interrupt gpioc_checker u_gpioc_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    import gpioc_pkg::*;

    // Op code 3 has no member in op_e; it must change nothing
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int  DIRECTED_ROWS  = 25;
    localparam int  ITEMS_PER_PASS = 363;
    localparam int  TAIL_CYCLES    = 8;
    localparam int  CYCLE_LIMIT    = 200000;

    // One row of the directed table: the transaction, and where the answer can be
    // read off at a glance, the result typed in by hand
    typedef struct {
        item_t   stim;
        bit      typed;
        result_t want;
    } row_t;

    localparam result_t PREDICTED = '0;

    // Directed table; pull-ups are enabled (pullups_off = 0) while it runs
    row_t directed_rows [DIRECTED_ROWS] = '{
        // after reset: every pin an input, nothing latched or sampled
        '{item_t'{OP_READ,   4'd0,  KIND_DIR,   8'h00, 8'h00}, 1'b1,
          result_t'{8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0}},
        '{item_t'{OP_READ,   4'd5,  KIND_FLAG,  8'hFF, 8'hFF}, 1'b1,
          result_t'{8'h00, 8'h00, 8'h00, 8'hFF, 1'b0}},
        '{item_t'{OP_READ,   4'd1,  KIND_PINS,  8'h00, 8'h00}, 1'b1,
          result_t'{8'h00, 8'h00, 8'h00, 8'hFF, 1'b0}},
        // upper nibble of port B moves away from the last read: flag rises
        '{item_t'{OP_SAMPLE, 4'd1,  KIND_DIR,   8'h00, 8'hA5}, 1'b1,
          result_t'{8'h00, 8'h00, 8'h00, 8'hFF, 1'b1}},
        // clearing the flag while the mismatch persists sets it again at once
        '{item_t'{OP_WRITE,  4'd1,  KIND_FLAG,  8'hFE, 8'h00}, 1'b1,
          result_t'{8'h00, 8'h00, 8'h00, 8'hFF, 1'b1}},
        // reading port B ends the mismatch but leaves the flag set
        '{item_t'{OP_READ,   4'd1,  KIND_PINS,  8'h00, 8'h00}, 1'b1,
          result_t'{8'hA5, 8'h00, 8'h00, 8'hFF, 1'b1}},
        '{item_t'{OP_WRITE,  4'd1,  KIND_FLAG,  8'h00, 8'hFF}, 1'b1,
          result_t'{8'h00, 8'h00, 8'h00, 8'hFF, 1'b0}},
        // port B upper nibble as outputs: those pins leave the compare
        '{item_t'{OP_WRITE,  4'd1,  KIND_DIR,   8'h0F, 8'h00}, 1'b0, PREDICTED},
        '{item_t'{OP_WRITE,  4'd1,  KIND_PINS,  8'hFF, 8'h00}, 1'b0, PREDICTED},
        '{item_t'{OP_READ,   4'd1,  KIND_PINS,  8'h00, 8'h00}, 1'b0, PREDICTED},
        '{item_t'{OP_SAMPLE, 4'd1,  KIND_DIR,   8'h00, 8'h00}, 1'b0, PREDICTED},
        '{item_t'{OP_READ,   4'd1,  KIND_FLAG,  8'h00, 8'h00}, 1'b0, PREDICTED},
        // port index out of range lands on port A
        '{item_t'{OP_WRITE,  4'd15, KIND_DIR,   8'h00, 8'hFF}, 1'b1,
          result_t'{8'h00, 8'hFF, 8'h00, 8'h0F, 1'b0}},
        '{item_t'{OP_WRITE,  4'd9,  KIND_LATCH, 8'h3C, 8'h00}, 1'b0, PREDICTED},
        '{item_t'{OP_READ,   4'd0,  KIND_LATCH, 8'h00, 8'h00}, 1'b0, PREDICTED},
        // last port in range
        '{item_t'{OP_SAMPLE, 4'd8,  KIND_LATCH, 8'h00, 8'hFF}, 1'b0, PREDICTED},
        '{item_t'{OP_READ,   4'd8,  KIND_PINS,  8'h00, 8'h00}, 1'b0, PREDICTED},
        // unused op touches nothing
        '{item_t'{OP_UNUSED, 4'd1,  KIND_FLAG,  8'hFF, 8'hFF}, 1'b0, PREDICTED},
        '{item_t'{OP_WRITE,  4'd8,  KIND_DIR,   8'h00, 8'h00}, 1'b0, PREDICTED},
        '{item_t'{OP_WRITE,  4'd8,  KIND_LATCH, 8'hFF, 8'h00}, 1'b0, PREDICTED},
        '{item_t'{OP_READ,   4'd8,  KIND_PINS,  8'h00, 8'h00}, 1'b0, PREDICTED},
        // port B back to all inputs: sampled zeros differ from the stored F
        '{item_t'{OP_WRITE,  4'd1,  KIND_DIR,   8'hFF, 8'h00}, 1'b0, PREDICTED},
        '{item_t'{OP_READ,   4'd15, KIND_FLAG,  8'h00, 8'h00}, 1'b0, PREDICTED},
        '{item_t'{OP_SAMPLE, 4'd12, KIND_PINS,  8'h00, 8'h5A}, 1'b0, PREDICTED},
        '{item_t'{OP_READ,   4'd0,  KIND_PINS,  8'h00, 8'h00}, 1'b0, PREDICTED}
    };

    // Clock, reset and the block's ports
    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_stall;
    item_t                 item_in;
    logic                  result_valid;
    logic                  result_stall;
    result_t               result_out;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Mirror of the port bank, advanced once per accepted transaction
    logic [7:0] port_dir     [NUM_PORTS];
    logic [7:0] port_latch   [NUM_PORTS];
    logic [7:0] port_sampled [NUM_PORTS];
    logic [3:0] portb_compare;
    logic       change_seen;
    logic       pullups_n;

    result_t    expected_results [$];
    result_t    oldest_expected;

    int         sender_idle_pct;
    int         receiver_stall_pct;
    int         error_count;
    int         results_checked;
    int         items_sent;
    int         pullup_writes;
    int         cycle_count;

    gpio_ports_with_change_interrupt DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Print one line per fault and count it
    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            flag_error($sformatf("%s got 0x%02h, expected 0x%02h", name, got, want));
    endtask

    // Pin view of a port: latch bits on outputs, sampled levels on inputs
    function automatic logic [7:0] merged_pins(input int p);
        return (port_latch[p] & ~port_dir[p]) | (port_sampled[p] & port_dir[p]);
    endfunction

    // Advance the mirror by one transaction and return the result it should give
    function automatic result_t gpio_bank_step(input item_t it);
        result_t    r;
        int         p;
        logic [7:0] rd;
        logic [7:0] pins_b;
        logic [3:0] moved;
        p  = (it.port_index < NUM_PORTS) ? int'(it.port_index) : 0;
        rd = 8'h00;
        case (it.op)
            OP_READ:
                case (it.reg_kind)
                    KIND_DIR:   rd = port_dir[p];
                    KIND_LATCH: rd = port_latch[p];
                    KIND_PINS:
                    begin
                        rd = merged_pins(p);
                        if (p == int'(PORT_B))
                            portb_compare = rd[7:4];
                    end
                    default:    rd = {7'b0, change_seen};
                endcase
            OP_WRITE:
                case (it.reg_kind)
                    KIND_DIR:   port_dir[p] = it.write_data;
                    KIND_LATCH,
                    KIND_PINS:  port_latch[p] = it.write_data;
                    default:    change_seen = it.write_data[0];
                endcase
            OP_SAMPLE:
                port_sampled[p] = it.pin_levels;
            default: ;
        endcase
        // Only port B input pins 7..4 take part in the compare
        pins_b = merged_pins(int'(PORT_B));
        moved  = (pins_b[7:4] ^ portb_compare) & port_dir[PORT_B][7:4];
        if (moved != 4'h0)
            change_seen = 1'b1;
        r.read_data    = rd;
        r.drive_enable = ~port_dir[p];
        r.drive_level  = port_latch[p] & ~port_dir[p];
        r.pullup_on    = pullups_n ? 8'h00 : port_dir[PORT_B];
        r.change_flag  = change_seen;
        return r;
    endfunction

    // Random transaction, weighted towards port B where the compare lives
    function automatic item_t random_item();
        item_t it;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 35)
            it.op = OP_READ;
        else if (pick < 65)
            it.op = OP_WRITE;
        else if (pick < 95)
            it.op = OP_SAMPLE;
        else
            it.op = OP_UNUSED;
        pick = $urandom_range(99);
        if (pick < 50)
            it.port_index = 4'(PORT_B);
        else if (pick < 90)
            it.port_index = 4'($urandom_range(NUM_PORTS - 1));
        else
            it.port_index = 4'($urandom_range(15, NUM_PORTS));
        it.reg_kind   = 2'($urandom_range(3));
        it.write_data = 8'($urandom_range(255));
        it.pin_levels = 8'($urandom_range(255));
        return it;
    endfunction

    // Offer one transaction; idle first at random, hold it until accepted, then
    // record the expectation at the accepting edge
    task automatic send_item(input item_t it, input bit typed, input result_t want);
        result_t predicted;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            item_in    <= item_t'($urandom);
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item_in    <= it;
        do
            @(posedge clk);
        while (item_stall);
        predicted = gpio_bank_step(it);
        expected_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Drop valid and let every outstanding result come back
    task automatic drain_results();
        @(negedge clk);
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic cfg_write(input cfg_reg_e which, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(4 * int'(which));
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // APB read, compared against what the register should hold
    task automatic cfg_check(input cfg_reg_e which, input logic [CFG_DATA_W-1:0] want);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CFG_ADDR_W'(4 * int'(which));
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
            flag_error($sformatf("register %s read 0x%0h, expected 0x%0h",
                                 which.name(), prdata, want));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Only called with the bank idle; keep the mirror in step and read back
    task automatic set_pullups_off(input logic value);
        cfg_write(REG_PULLUPS_OFF, {31'b0, value});
        pullups_n = value;
        pullup_writes++;
        cfg_check(REG_PULLUPS_OFF, {31'b0, value});
    endtask

    // Receiver: decide the stall for the next edge at each falling edge
    always @(negedge clk)
        result_stall <= ($urandom_range(99) < receiver_stall_pct);

    // Take each result and compare it with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
                flag_error("result arrived with nothing expected");
            else
            begin
                oldest_expected = expected_results.pop_front();
                compare_field("read_data",    result_out.read_data,
                              oldest_expected.read_data);
                compare_field("drive_enable", result_out.drive_enable,
                              oldest_expected.drive_enable);
                compare_field("drive_level",  result_out.drive_level,
                              oldest_expected.drive_level);
                compare_field("pullup_on",    result_out.pullup_on,
                              oldest_expected.pullup_on);
                compare_field("change_flag",  {7'b0, result_out.change_flag},
                              {7'b0, oldest_expected.change_flag});
                results_checked++;
            end
        end
    end

    // Watchdog: stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TIMEOUT after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        // Drive every input to a known value from time zero
        rst_n              = 1'b0;
        item_valid         = 1'b0;
        item_in            = '0;
        result_stall       = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        error_count        = 0;
        results_checked    = 0;
        items_sent         = 0;
        pullup_writes      = 0;
        cycle_count        = 0;

        // Initialise the mirror to the reset state
        for (int i = 0; i < NUM_PORTS; i++)
        begin
            port_dir[i]     = 8'hFF;
            port_latch[i]   = 8'h00;
            port_sampled[i] = 8'h00;
        end
        portb_compare = 4'h0;
        change_seen   = 1'b0;
        pullups_n     = 1'b1;

        // Hold reset, then release it on a falling edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Pull-ups come out of reset disabled; enable them for the table
        cfg_check(REG_PULLUPS_OFF, 32'd1);
        set_pullups_off(1'b0);

        // Directed table, back to back with no stalls
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
        drain_results();

        // Random passes: no idling, sender idle, receiver stalling, both lightly;
        // the pull-up setting alternates between passes
        for (int pass = 0; pass < 4; pass++)
        begin
            case (pass)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 76; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 76; end
                default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
            endcase
            set_pullups_off(pass[0]);
            for (int n = 0; n < ITEMS_PER_PASS; n++)
                send_item(random_item(), 1'b0, PREDICTED);
            drain_results();
        end

        // Let the pipeline settle, then look for anything stray
        receiver_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_results.size()));

        $display("Covered %0d transactions (%0d directed rows, four random passes),",
                 items_sent, DIRECTED_ROWS);
        $display("%0d results compared, pull-up register written %0d times, %0d faults.",
                 results_checked, pullup_writes, error_count);
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
